@@ rtl/ddpi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddpi_pkg
// shared constants, types and tables of the pose integrator
// ----------------------------------------------------------------------------
package ddpi_pkg;

   localparam int CordicSteps = 16;
   localparam int AngleBits   = 16;
   localparam int StepBits    = $clog2(CordicSteps + 1);

   // vector width: 21 bit distance times 30 bit gain plus growth margin
   localparam int VecBits = 56;

   localparam logic [31:0] GainInvQ30   = 32'd652032874;
   localparam logic [31:0] InvTwoPiQ32  = 32'd683565276;

   localparam logic [15:0] TimeStepReset     = 16'd6554;
   localparam logic [15:0] InvWheelBaseReset = 16'd1829;

   localparam logic CsrTimeStep     = 1'b0;
   localparam logic CsrInvWheelBase = 1'b1;

   typedef logic [31:0] atan_table_type [0:23];
   localparam atan_table_type AtanTurn32 = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   function automatic logic signed [AngleBits:0] atan_step(input logic [4:0] i);
      logic [32:0] t;
      t = {1'b0, AtanTurn32[i]} + (33'd1 << (31 - AngleBits));
      return $signed({1'b0, t[31 -: AngleBits]});
   endfunction

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MUL1   = 7'b0000010,
      ST_MUL2   = 7'b0000100,
      ST_GAIN   = 7'b0001000,
      ST_ROT    = 7'b0010000,
      ST_UPDATE = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;     // capture input beat
      logic mul1;     // distance and turn product 1
      logic mul2;     // turn products 2
      logic gain;     // gain, fold, heading delta
      logic rot;      // one cordic iteration
      logic update;   // commit pose
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic is_zero;
      logic rot_done;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/ddpi_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddpi_datapath
// multiplies, shared cordic rotator and pose registers
// ----------------------------------------------------------------------------
module ddpi_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  ddpi_pkg::cmd_type     cmd,
   output ddpi_pkg::status_type  status,
   input  wire  [0:0]            in_mode,
   input  wire  signed [15:0]    in_left,
   input  wire  signed [15:0]    in_right,
   input  wire  signed [31:0]    in_x,
   input  wire  signed [31:0]    in_y,
   input  wire  [15:0]           in_heading,
   input  wire  [15:0]           time_step,
   input  wire  [15:0]           inv_wheel_base,
   output logic signed [31:0]    pos_x,
   output logic signed [31:0]    pos_y,
   output logic [15:0]           heading,
   output logic                  saturated
);
   import ddpi_pkg::*;

   logic               mode_ff;
   logic signed [16:0] sum_ff, diff_ff;
   logic signed [31:0] ldx_ff, ldy_ff;
   logic [15:0]        lh_ff;
   logic signed [20:0] d_ff;          // rounded distance
   logic signed [33:0] tw_ff;         // diff * inv_wheel_base
   logic signed [33:0] r_ff;          // rounded turn, Q.20 rad
   logic [15:0]        dh_ff;
   logic signed [VecBits-1:0] x_ff, y_ff;
   logic signed [AngleBits:0] z_ff;
   logic [StepBits-1:0] i_ff;
   logic signed [31:0] px_ff, py_ff;
   logic [15:0]        ph_ff;
   logic               sat_ff;

   logic signed [33:0] dprod;
   logic signed [50:0] pprod;
   logic signed [51:0] gprod;
   logic signed [67:0] hprod;
   logic signed [VecBits-1:0] xs, ys, x0;
   logic [AngleBits-1:0] a;
   logic signed [AngleBits:0] t;
   logic signed [VecBits-1:0] rx, ry;
   logic signed [33:0] sx, sy;
   logic signed [33:0] dxr, dyr;
   logic sx_hi, sx_lo, sy_hi, sy_lo;

   always_comb begin
      dprod = sum_ff * $signed({1'b0, time_step});
      pprod = $signed({{17{tw_ff[33]}}, tw_ff}) * $signed({35'd0, time_step});
      gprod = $signed({{31{d_ff[20]}}, d_ff}) * $signed({20'd0, GainInvQ30});
      hprod = $signed({{34{r_ff[33]}}, r_ff}) * $signed({36'd0, InvTwoPiQ32});
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      t  = atan_step(5'(i_ff));
      x0 = VecBits'((gprod + 52'sd8192) >>> 14);
      a  = AngleBits'({16'(ph_ff), 8'd0} >> (24 - AngleBits));
      rx = (x_ff + (VecBits'(1) <<< 15)) >>> 16;
      ry = (y_ff + (VecBits'(1) <<< 15)) >>> 16;
      dxr = 34'(rx);
      dyr = 34'(ry);
      sx = 34'(px_ff) + dxr;
      sy = 34'(py_ff) + dyr;
      sx_hi = sx > 34'sh07FFFFFFF;
      sx_lo = sx < -34'sh080000000;
      sy_hi = sy > 34'sh07FFFFFFF;
      sy_lo = sy < -34'sh080000000;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= in_mode[0];
         sum_ff  <= 17'(in_right) + 17'(in_left);
         diff_ff <= 17'(in_right) - 17'(in_left);
         ldx_ff  <= in_x;
         ldy_ff  <= in_y;
         lh_ff   <= in_heading;
      end
      if (cmd.mul1) begin
         d_ff  <= 21'((dprod + 34'sd4096) >>> 13);
         tw_ff <= diff_ff * $signed({1'b0, inv_wheel_base});
      end
      if (cmd.mul2) begin
         r_ff <= 34'((pprod + 51'sd32768) >>> 16);
      end
      if (cmd.gain) begin
         dh_ff <= 16'((hprod + (68'sd1 <<< 35)) >>> 36);
         y_ff  <= '0;
         i_ff  <= '0;
         if (a[AngleBits-1] != a[AngleBits-2]) begin
            x_ff <= -x0;
            z_ff <= $signed({1'b0, a}) - $signed({2'b01, {(AngleBits-1){1'b0}}});
         end else begin
            x_ff <= x0;
            z_ff <= a[AngleBits-1] ? $signed({1'b1, a}) : $signed({1'b0, a});
         end
      end
      if (cmd.rot) begin
         i_ff <= i_ff + 1'b1;
         if (!z_ff[AngleBits]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - t;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff  <= '0;
         py_ff  <= '0;
         ph_ff  <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.update) begin
         if (mode_ff) begin
            px_ff  <= ldx_ff;
            py_ff  <= ldy_ff;
            ph_ff  <= lh_ff;
            sat_ff <= 1'b0;
         end else if (sum_ff == '0 && diff_ff == '0) begin
            sat_ff <= 1'b0;
         end else begin
            px_ff  <= sx_hi ? 32'sh7FFFFFFF : sx_lo ? -32'sh80000000 : 32'(sx);
            py_ff  <= sy_hi ? 32'sh7FFFFFFF : sy_lo ? -32'sh80000000 : 32'(sy);
            ph_ff  <= ph_ff + dh_ff;
            sat_ff <= sx_hi | sx_lo | sy_hi | sy_lo;
         end
      end
   end

   assign status.is_load  = mode_ff;
   assign status.is_zero  = (sum_ff == '0) && (diff_ff == '0);
   assign status.rot_done = (i_ff == StepBits'(CordicSteps - 1));
   assign pos_x     = px_ff;
   assign pos_y     = py_ff;
   assign heading   = ph_ff;
   assign saturated = sat_ff;
endmodule
`default_nettype wire

@@ rtl/ddpi_control.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddpi_control
// sequencer for one item: multiplies, cordic iterations, commit, output
// ----------------------------------------------------------------------------
module ddpi_control (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  wire                   out_ready,
   input  ddpi_pkg::status_type  status,
   output ddpi_pkg::cmd_type     cmd
);
   import ddpi_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = in_valid;
            if (in_valid) state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = (status.is_load || status.is_zero) ? ST_UPDATE : ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain = 1'b1;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cmd.rot = 1'b1;
            if (status.rot_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
endmodule
`default_nettype wire

@@ rtl/differential_drive_pose_integrator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_pose_integrator_top
// euler odometry step with cordic rotation of the forward distance
//
// channel  dir  beat contents
// req      in   tuser mode, tdata speeds and load pose
// rsp      out  tdata pose, tuser saturated
// csr      in   index and 16 bit register value
//
// step item: accept, the multiply states MUL1, MUL2 and GAIN, then the 16 cordic
// iterations on one shared rotator and a commit in UPDATE before rsp_tvalid
// load items and zero speed steps: MUL1 and the commit only, no cordic
// one item at a time; rsp holds until rsp_tready
// synchronous reset clears pose to zero and registers to defaults
// ----------------------------------------------------------------------------
module differential_drive_pose_integrator_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [0:0]   req_tuser,   // mode
   input  wire  [111:0] req_tdata,   // left_speed, right_speed, load_x, load_y, load_heading
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [79:0]  rsp_tdata,   // pos_x, pos_y, heading
   output logic [0:0]   rsp_tuser,   // saturated
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [0:0]   csr_index,
   input  wire  [15:0]  csr_data
);
   import ddpi_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [15:0] ts_ff, iwb_ff;
   logic signed [31:0] px, py;
   logic [15:0] hd;
   logic        sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff  <= TimeStepReset;
         iwb_ff <= InvWheelBaseReset;
      end else if (csr_valid) begin
         if (csr_index[0] == CsrTimeStep)     ts_ff  <= csr_data;
         if (csr_index[0] == CsrInvWheelBase) iwb_ff <= csr_data;
      end
   end
   assign csr_ready = 1'b1;

   ddpi_control u_control (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ddpi_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_mode        (req_tuser),
      .in_left        (req_tdata[15:0]),
      .in_right       (req_tdata[31:16]),
      .in_x           (req_tdata[63:32]),
      .in_y           (req_tdata[95:64]),
      .in_heading     (req_tdata[111:96]),
      .time_step      (ts_ff),
      .inv_wheel_base (iwb_ff),
      .pos_x          (px),
      .pos_y          (py),
      .heading        (hd),
      .saturated      (sat)
   );

   assign rsp_tdata = {hd, py, px};
   assign rsp_tuser = sat;
endmodule
`default_nettype wire

@@ dv/tb_differential_drive_pose_integrator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_differential_drive_pose_integrator_top
// checks odometry steps and pose loads against a bit-exact pose predictor,
// with bursty requests, response stalls and register changes between phases
// ----------------------------------------------------------------------------
module tb_differential_drive_pose_integrator_top;
   import ddpi_pkg::*;

   localparam int WatchdogLimit = 20000;

   typedef struct {
      logic        mode;
      logic [15:0] left_speed;
      logic [15:0] right_speed;
      logic [31:0] load_x;
      logic [31:0] load_y;
      logic [15:0] load_heading;
   } odo_item_t;

   typedef struct {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] heading;
      logic        saturated;
   } pose_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [0:0]    req_tuser = '0;
   logic [111:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [79:0]   rsp_tdata;
   logic [0:0]    rsp_tuser;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [0:0]    csr_index = '0;
   logic [15:0]   csr_data = '0;

   odo_item_t  pending_items[$];
   pose_t      expected_poses[$];
   int         mismatch_count = 0;
   int         idle_cycles = 0;
   int         burst_left = 0;
   int         gap_left = 0;
   int         stall_phase = 0;
   bit         driver_hold = 1'b0;

   // predictor state
   logic signed [31:0] model_x, model_y;
   logic [15:0]        model_heading, model_time_step, model_inv_base;

   differential_drive_pose_integrator_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint floor_div(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_div(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v, ref bit clamped);
      if (v > 64'sd2147483647) begin
         clamped = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clamped = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic pose_t advance_pose(odo_item_t it);
      pose_t   p;
      bit      clamped;
      longint  vl, vr, fwd_dist, a, z, vx, vy, xs, ys, t, turn, dh;
      longint  quarter;
      clamped = 1'b0;
      quarter = longint'(1) <<< (AngleBits - 2);
      if (it.mode) begin
         model_x = it.load_x;
         model_y = it.load_y;
         model_heading = it.load_heading;
      end else begin
         vl = longint'($signed(it.left_speed));
         vr = longint'($signed(it.right_speed));
         if (vl != 0 || vr != 0) begin
            fwd_dist = round_div((vr + vl) * longint'(model_time_step), 13);
            a = longint'(model_heading);
            vx = round_div(fwd_dist * longint'(GainInvQ30), 14);
            vy = 0;
            if (a >= quarter && a < 3 * quarter) begin
               vx = -vx;
               z = a - 2 * quarter;
            end else if (a >= 3 * quarter) begin
               z = a - 4 * quarter;
            end else begin
               z = a;
            end
            for (int i = 0; i < CordicSteps; i++) begin
               t = (longint'(AtanTurn32[i]) + (longint'(1) <<< (31 - AngleBits)))
                   >>> (32 - AngleBits);
               xs = floor_div(vx, i);
               ys = floor_div(vy, i);
               if (z >= 0) begin
                  vx -= ys; vy += xs; z -= t;
               end else begin
                  vx += ys; vy -= xs; z += t;
               end
            end
            model_x = 32'(clamp32(longint'(model_x) + round_div(vx, 16), clamped));
            model_y = 32'(clamp32(longint'(model_y) + round_div(vy, 16), clamped));
            turn = round_div((vr - vl) * longint'(model_inv_base)
                             * longint'(model_time_step), 16);
            dh = round_div(turn * longint'(InvTwoPiQ32), 36);
            model_heading = model_heading + dh[15:0];
         end
      end
      p.pos_x = model_x;
      p.pos_y = model_y;
      p.heading = model_heading;
      p.saturated = clamped;
      return p;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_poses.push_back(advance_pose(pending_items.pop_front()));
         if (req_tvalid && !req_tready) begin
            // hold the beat
         end else if (driver_hold || pending_items.size() == 0
                      || (req_tvalid && req_tready && pending_items.size() == 0)) begin
            req_tvalid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else begin
            // the next pending item after any pop above
            req_tvalid <= 1'b1;
            req_tuser <= pending_items[0].mode;
            req_tdata <= {pending_items[0].load_heading, pending_items[0].load_y,
                          pending_items[0].load_x, pending_items[0].right_speed,
                          pending_items[0].left_speed};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // monitor and response stalls
   always @(posedge clock) begin
      pose_t want, got;
      if (!reset) begin
         stall_phase <= stall_phase + 1;
         rsp_tready <= (stall_phase % 256 < 96) ? 1'b1 : ($urandom_range(0, 2) != 0);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.pos_x = rsp_tdata[31:0];
            got.pos_y = rsp_tdata[63:32];
            got.heading = rsp_tdata[79:64];
            got.saturated = rsp_tuser[0];
            if (expected_poses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected beat x=%h y=%h h=%h s=%b", got.pos_x, got.pos_y,
                           got.heading, got.saturated);
            end else begin
               want = expected_poses.pop_front();
               if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y
                   || got.heading !== want.heading || got.saturated !== want.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch exp x=%h y=%h h=%h s=%b got x=%h y=%h h=%h s=%b",
                              want.pos_x, want.pos_y, want.heading, want.saturated,
                              got.pos_x, got.pos_y, got.heading, got.saturated);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic odo_item_t make_step(logic [15:0] vl, logic [15:0] vr);
      odo_item_t it;
      it.mode = 1'b0;
      it.left_speed = vl;
      it.right_speed = vr;
      it.load_x = $urandom;
      it.load_y = $urandom;
      it.load_heading = 16'($urandom);
      return it;
   endfunction

   function automatic odo_item_t make_load(logic [31:0] x, logic [31:0] y,
                                           logic [15:0] h);
      odo_item_t it;
      it = make_step(16'($urandom), 16'($urandom));
      it.mode = 1'b1;
      it.load_x = x;
      it.load_y = y;
      it.load_heading = h;
      return it;
   endfunction

   task automatic drain_all();
      while (pending_items.size() != 0 || req_tvalid || expected_poses.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] index, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CsrTimeStep)
         model_time_step = value;
      else
         model_inv_base = value;
      @(posedge clock);
   endtask

   task automatic queue_random(int count);
      logic [15:0] vl, vr;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: pending_items.push_back(make_load($urandom, $urandom, 16'($urandom)));
            1: pending_items.push_back(make_load({$urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                                                  16'($urandom)},
                                                 $urandom, 16'($urandom)));
            2: pending_items.push_back(make_step(0, 0));
            3: pending_items.push_back(make_step(16'($urandom), 16'($urandom)));
            default: begin
               vl = 16'($signed($urandom_range(0, 8191)) - 4096);
               vr = $urandom_range(0, 3) == 0 ? vl : 16'($signed($urandom_range(0, 8191)) - 4096);
               pending_items.push_back(make_step(vl, vr));
            end
         endcase
      end
   endtask

   initial begin
      model_x = 0;
      model_y = 0;
      model_heading = 0;
      model_time_step = TimeStepReset;
      model_inv_base = InvWheelBaseReset;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero speeds, folds, saturation, wrap
      pending_items.push_back(make_step(0, 0));
      pending_items.push_back(make_step(16'h1000, 16'h1000));
      pending_items.push_back(make_step(16'h7FFF, 16'h7FFF));
      pending_items.push_back(make_step(16'h8000, 16'h8000));
      pending_items.push_back(make_step(16'h8000, 16'h7FFF));
      pending_items.push_back(make_step(16'h7FFF, 16'h8000));
      pending_items.push_back(make_step(16'hFFFF, 16'h0001));
      for (int q = 0; q < 8; q++) begin
         pending_items.push_back(make_load(0, 0, 16'(q * 16'h2000)));
         pending_items.push_back(make_step(16'h2000, 16'h2000));
      end
      pending_items.push_back(make_load(32'h7FFFFFF0, 32'h80000010, 16'h4000));
      pending_items.push_back(make_step(16'h7FFF, 16'h7FFF));
      pending_items.push_back(make_load(32'h80000010, 32'h7FFFFFF0, 16'hFFFF));
      pending_items.push_back(make_step(16'h8000, 16'h8000));
      pending_items.push_back(make_load(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF));
      pending_items.push_back(make_step(16'h0000, 16'h7FFF));
      drain_all();

      write_csr(CsrTimeStep, 16'hFFFF);
      write_csr(CsrInvWheelBase, 16'hFFFF);
      pending_items.push_back(make_step(16'h8000, 16'h7FFF));
      pending_items.push_back(make_step(16'h7FFF, 16'h7FFF));
      queue_random(300);
      drain_all();

      write_csr(CsrTimeStep, 16'd1);
      write_csr(CsrInvWheelBase, 16'd1);
      queue_random(200);
      drain_all();

      write_csr(CsrTimeStep, 16'd0);
      write_csr(CsrInvWheelBase, 16'd0);
      queue_random(80);
      // sender holds off until everything has come back
      while (pending_items.size() > 40) @(posedge clock);
      driver_hold = 1'b1;
      while (req_tvalid || expected_poses.size() != 0) @(posedge clock);
      driver_hold = 1'b0;
      drain_all();

      for (int phase = 0; phase < 4; phase++) begin
         write_csr(CsrTimeStep, 16'($urandom_range(1, 65535)));
         write_csr(CsrInvWheelBase, 16'($urandom_range(1, 65535)));
         queue_random(150);
         drain_all();
      end

      write_csr(CsrTimeStep, TimeStepReset);
      write_csr(CsrInvWheelBase, InvWheelBaseReset);
      queue_random(60);
      drain_all();

      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ddpi_pkg.sv
rtl/ddpi_datapath.sv
rtl/ddpi_control.sv
rtl/differential_drive_pose_integrator_top.sv
dv/tb_differential_drive_pose_integrator_top.sv
